// ----- sv/kmh_pkg.sv -----
// Shared types and constants for the key modifier histogram.
// Holds action codes, modifier flag positions, register indexes and the decode result.
// No dependencies.
package kmh_pkg;

   localparam int KEY_W        = 8;
   localparam int COMBO_W      = 4;
   localparam int COMBOS       = 16;
   localparam int FLAGS_W      = 5;
   localparam int OUT_COUNT_W  = 32;
   localparam int WVAL_W       = 32;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 64;
   localparam int CAPS_REGS    = 4;
   localparam int CAPS_BITS    = CAPS_REGS * CSR_DATA_W;

   // Modifier flag positions, shift in bit 0
   localparam int FL_SHIFT   = 0;
   localparam int FL_CONTROL = 1;
   localparam int FL_OPTION  = 2;
   localparam int FL_COMMAND = 3;
   localparam int FL_CAPS    = 4;

   typedef enum logic [1:0] {
      ACT_KEY_DOWN = 2'd0,
      ACT_FLAGS    = 2'd1,
      ACT_READ     = 2'd2,
      ACT_WRITE    = 2'd3
   } act_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPS_LOW      = 8'd0,
      CSR_CAPS_MID_LOW  = 8'd1,
      CSR_CAPS_MID_HIGH = 8'd2,
      CSR_CAPS_HIGH     = 8'd3
   } csr_idx_type;

   // Outcome of decoding one request word
   typedef struct packed {
      logic               in_range;
      logic               counted;
      logic [COMBO_W-1:0] combo_addr;
      logic [COMBO_W-1:0] combo_used;
   } dec_type;

endpackage

// ----- sv/kmh_ram.sv -----
// Single-port-write, single-port-read count table with registered read data.
// Depends on nothing.
module kmh_ram #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/kmh_decode.sv -----
// Request decoder: range check, modifier edge detection and column selection.
// Depends on kmh_pkg.
module kmh_decode
   import kmh_pkg::*;
#(
   parameter int KEY_CODES = 256
) (
   input  act_type              action,
   input  logic [KEY_W-1:0]     key_code,
   input  logic [FLAGS_W-1:0]   flags,
   input  logic [FLAGS_W-1:0]   last_flags,
   input  logic [COMBO_W-1:0]   modifier_combo,
   input  logic [CAPS_BITS-1:0] caps_mask,
   output dec_type              dec
);

   logic [FLAGS_W-1:0] watched;
   logic               in_range;
   logic               press;
   logic [FLAGS_W-1:0] ev_flags;

   // Flag watched by each modifier key code
   always_comb begin
      watched = '0;
      unique case (key_code)
         8'd54, 8'd55: watched[FL_COMMAND] = 1'b1;
         8'd56, 8'd60: watched[FL_SHIFT]   = 1'b1;
         8'd58, 8'd61: watched[FL_OPTION]  = 1'b1;
         8'd59, 8'd62: watched[FL_CONTROL] = 1'b1;
         8'd57:        watched[FL_CAPS]    = 1'b1;
         default:      watched = '0;
      endcase
   end

   assign in_range = ({1'b0, key_code} < (KEY_W+1)'(KEY_CODES));

   always_comb begin
      ev_flags = flags;
      if (flags[FL_CAPS] && caps_mask[key_code]) begin
         ev_flags[FL_SHIFT] = 1'b1;
      end
   end

   always_comb begin
      press = 1'b0;
      dec   = '0;
      dec.in_range = in_range;
      unique case (action)
         ACT_KEY_DOWN: press = 1'b1;
         ACT_FLAGS:    press = |(watched & flags & ~last_flags);
         ACT_READ,
         ACT_WRITE:    press = 1'b0;
         default:      press = 1'b0;
      endcase
      if (action == ACT_READ || action == ACT_WRITE) begin
         dec.combo_addr = modifier_combo;
         dec.combo_used = modifier_combo;
      end else begin
         dec.counted    = press && in_range;
         dec.combo_addr = ev_flags[COMBO_W-1:0];
         dec.combo_used = (press && in_range) ? ev_flags[COMBO_W-1:0] : '0;
      end
   end

endmodule

// ----- sv/key_modifier_histogram.sv -----
// Top level of the key modifier histogram: control, configuration and count table.
// Depends on kmh_pkg, kmh_decode and kmh_ram.
//
// Usage
//   Request channel: drive start with the req_ fields; a word is taken at a
//   rising edge where start is high and busy is low. Key-down and
//   flags-changed words count presses into a table of KEY_CODES rows by 16
//   modifier columns; read and write words access one entry directly.
//   Response channel: exactly one word per request, shown for one cycle with
//   rsp_valid high. The receiver cannot stall; it must take the word then.
//   Response path: the accepted word is held in registers over the update
//   state, and the response word is registered at its end.
//   Request pacing: busy is high in the update state, so a new request waits
//   for the read-modify-write loop (synchronous read, write back) to finish.
//   Configuration: csr_ writes set the four 64-bit caps lock masks; csr_ready
//   is always high. Write them only while the block is idle.
//   Reset: synchronous, active high. Afterwards the table is cleared one entry
//   a cycle, all KEY_CODES*16 entries (4096 at default), with busy high; the
//   caps masks and the stored last modifier flags reset to zero.
module key_modifier_histogram
   import kmh_pkg::*;
#(
   parameter int KEY_CODES   = 256,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_action,
   input  logic [KEY_W-1:0]       req_key_code,
   input  logic                   req_shift_held,
   input  logic                   req_control_held,
   input  logic                   req_option_held,
   input  logic                   req_command_held,
   input  logic                   req_caps_lock_on,
   input  logic [COMBO_W-1:0]     req_modifier_combo,
   input  logic [WVAL_W-1:0]      req_write_value,
   // response channel
   output logic                   rsp_valid,
   output logic                   rsp_counted,
   output logic [OUT_COUNT_W-1:0] rsp_count_value,
   output logic [COMBO_W-1:0]     rsp_combo_used,
   // configuration channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH  = KEY_CODES * COMBOS;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      clr_addr_ff, clr_addr_in;
   logic [FLAGS_W-1:0]     last_flags_ff, last_flags_in;
   logic [CSR_DATA_W-1:0]  caps_ff [CAPS_REGS];
   logic [CAPS_BITS-1:0]   caps_vec;

   // Request held over the update cycle
   act_type                act_ff;
   dec_type                dec_ff;
   logic [ADDR_W-1:0]      addr_ff;
   logic [COUNT_WIDTH-1:0] wval_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_counted_ff, rsp_counted_in;
   logic [OUT_COUNT_W-1:0] rsp_value_ff, rsp_value_in;
   logic [COMBO_W-1:0]     rsp_combo_ff, rsp_combo_in;

   logic                   accept;
   act_type                req_act;
   logic [FLAGS_W-1:0]     req_flags;
   dec_type                dec;
   logic [ADDR_W-1:0]      req_addr;

   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [COUNT_WIDTH-1:0] ram_wr_data;
   logic [COUNT_WIDTH-1:0] ram_rd_data;
   logic [COUNT_WIDTH-1:0] inc_val;
   logic                   ram_rd_en;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign req_act   = act_type'(req_action);

   always_comb begin
      req_flags = '0;
      req_flags[FL_SHIFT]   = req_shift_held;
      req_flags[FL_CONTROL] = req_control_held;
      req_flags[FL_OPTION]  = req_option_held;
      req_flags[FL_COMMAND] = req_command_held;
      req_flags[FL_CAPS]    = req_caps_lock_on;
   end

   always_comb begin
      for (int i = 0; i < CAPS_REGS; i++) begin
         caps_vec[i*CSR_DATA_W +: CSR_DATA_W] = caps_ff[i];
      end
   end

   kmh_decode #(
      .KEY_CODES (KEY_CODES)
   ) u_decode (
      .action         (req_act),
      .key_code       (req_key_code),
      .flags          (req_flags),
      .last_flags     (last_flags_ff),
      .modifier_combo (req_modifier_combo),
      .caps_mask      (caps_vec),
      .dec            (dec)
   );

   // Row and column form the table address; in-range keys fit ADDR_W bits
   assign req_addr  = ADDR_W'({req_key_code, dec.combo_addr});
   assign ram_rd_en = accept && dec.in_range;

   // Saturating increment of the entry read back
   assign inc_val = (&ram_rd_data) ? ram_rd_data : ram_rd_data + COUNT_WIDTH'(1);

   // Table write port: zero sweep after reset, otherwise write back or direct write
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = inc_val;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
         end
         ST_UPDATE: begin
            if (act_ff == ACT_WRITE) begin
               ram_wr_en   = dec_ff.in_range;
               ram_wr_data = wval_ff;
            end else begin
               ram_wr_en = dec_ff.counted;
            end
         end
         ST_IDLE: ram_wr_en = 1'b0;
         default: ram_wr_en = 1'b0;
      endcase
   end

   kmh_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (COUNT_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // Next state, response and last-flags logic
   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      last_flags_in  = last_flags_ff;
      rsp_valid_in   = 1'b0;
      rsp_counted_in = 1'b0;
      rsp_value_in   = '0;
      rsp_combo_in   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_UPDATE;
               // Events with a valid key always record their flags
               if ((req_act == ACT_KEY_DOWN || req_act == ACT_FLAGS) && dec.in_range) begin
                  last_flags_in = req_flags;
               end
            end
         end
         ST_UPDATE: begin
            state_in       = ST_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_counted_in = dec_ff.counted;
            rsp_combo_in   = dec_ff.combo_used;
            unique case (act_ff)
               ACT_READ:  rsp_value_in = dec_ff.in_range ? OUT_COUNT_W'(ram_rd_data) : '0;
               ACT_WRITE: rsp_value_in = dec_ff.in_range ? OUT_COUNT_W'(wval_ff) : '0;
               ACT_KEY_DOWN,
               ACT_FLAGS: rsp_value_in = dec_ff.counted ? OUT_COUNT_W'(inc_val) : '0;
               default:   rsp_value_in = '0;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         last_flags_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_counted_ff <= 1'b0;
         rsp_value_ff   <= '0;
         rsp_combo_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         last_flags_ff  <= last_flags_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_counted_ff <= rsp_counted_in;
         rsp_value_ff   <= rsp_value_in;
         rsp_combo_ff   <= rsp_combo_in;
      end
   end

   // Hold the accepted word for the update cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= req_act;
         dec_ff  <= dec;
         addr_ff <= req_addr;
         wval_ff <= COUNT_WIDTH'(req_write_value);
      end
   end

   // Caps lock masks; indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAPS_REGS; i++) begin
            caps_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CAPS_LOW:      caps_ff[0] <= csr_wdata;
            CSR_CAPS_MID_LOW:  caps_ff[1] <= csr_wdata;
            CSR_CAPS_MID_HIGH: caps_ff[2] <= csr_wdata;
            CSR_CAPS_HIGH:     caps_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_counted     = rsp_counted_ff;
   assign rsp_count_value = rsp_value_ff;
   assign rsp_combo_used  = rsp_combo_ff;

   // Every accepted word yields its response, registered out of the update state
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("response missing after accepted request");

   // No request is taken while the table is being cleared
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> busy)
      else $error("block not busy during clearing pass");

   // A counted response only comes from a key-down or flags-changed word
   a_counted_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_counted |-> $past(act_ff == ACT_KEY_DOWN || act_ff == ACT_FLAGS))
      else $error("counted response from a table access");

endmodule

// ----- test/key_modifier_histogram_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for key_modifier_histogram: a directed table of words, then random
// phases under several caps mask settings, every response checked against its row or the tally.
// Depends on kmh_pkg and the key_modifier_histogram RTL; reads no files.
module key_modifier_histogram_tb;
   import kmh_pkg::*;

   localparam int KEY_CODES     = 256;
   localparam int CYCLE_LIMIT   = 100000;   // clearing pass plus ~1300 words, with lots of slack
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_WORDS   = 325;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [OUT_COUNT_W-1:0] COUNT_TOP = '1;

   // Modifier key codes and the flag each one watches
   localparam logic [KEY_W-1:0] KEY_RIGHT_COMMAND = 8'd54;
   localparam logic [KEY_W-1:0] KEY_LEFT_COMMAND  = 8'd55;
   localparam logic [KEY_W-1:0] KEY_LEFT_SHIFT    = 8'd56;
   localparam logic [KEY_W-1:0] KEY_CAPS_LOCK     = 8'd57;
   localparam logic [KEY_W-1:0] KEY_LEFT_OPTION   = 8'd58;
   localparam logic [KEY_W-1:0] KEY_LEFT_CONTROL  = 8'd59;
   localparam logic [KEY_W-1:0] KEY_RIGHT_SHIFT   = 8'd60;
   localparam logic [KEY_W-1:0] KEY_RIGHT_OPTION  = 8'd61;
   localparam logic [KEY_W-1:0] KEY_RIGHT_CONTROL = 8'd62;

   localparam logic [FLAGS_W-1:0] HOLD_SHIFT   = FLAGS_W'(1 << FL_SHIFT);
   localparam logic [FLAGS_W-1:0] HOLD_CONTROL = FLAGS_W'(1 << FL_CONTROL);
   localparam logic [FLAGS_W-1:0] HOLD_OPTION  = FLAGS_W'(1 << FL_OPTION);
   localparam logic [FLAGS_W-1:0] HOLD_COMMAND = FLAGS_W'(1 << FL_COMMAND);
   localparam logic [FLAGS_W-1:0] HOLD_CAPS    = FLAGS_W'(1 << FL_CAPS);
   localparam logic [FLAGS_W-1:0] HOLD_NONE    = '0;

   typedef struct {
      act_type            action;
      logic [KEY_W-1:0]   key;
      logic [FLAGS_W-1:0] flags;
      logic [COMBO_W-1:0] combo;
      logic [WVAL_W-1:0]  wval;
   } hist_req_type;

   typedef struct {
      logic                   counted;
      logic [OUT_COUNT_W-1:0] value;
      logic [COMBO_W-1:0]     used;
   } hist_rsp_type;

   typedef struct {
      hist_req_type req;
      bit           typed;   // response typed into the row rather than taken from the tally
      hist_rsp_type rsp;
   } stim_row_type;

   // DUT inputs start at known values; everything after is driven at rising edges
   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   start              = 1'b0;
   logic                   busy;
   logic [1:0]             req_action         = '0;
   logic [KEY_W-1:0]       req_key_code       = '0;
   logic                   req_shift_held     = 1'b0;
   logic                   req_control_held   = 1'b0;
   logic                   req_option_held    = 1'b0;
   logic                   req_command_held   = 1'b0;
   logic                   req_caps_lock_on   = 1'b0;
   logic [COMBO_W-1:0]     req_modifier_combo = '0;
   logic [WVAL_W-1:0]      req_write_value    = '0;
   logic                   rsp_valid;
   logic                   rsp_counted;
   logic [OUT_COUNT_W-1:0] rsp_count_value;
   logic [COMBO_W-1:0]     rsp_combo_used;
   logic                   csr_valid          = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index          = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata          = '0;

   // Local copy of the block's state: press counts, last flags and caps masks
   logic [OUT_COUNT_W-1:0] tally [0:KEY_CODES*COMBOS-1];
   logic [FLAGS_W-1:0]     last_flags = '0;
   logic [CSR_DATA_W-1:0]  caps_mask [0:CAPS_REGS-1];

   hist_rsp_type awaited_tallies[$];   // responses still owed by the block, oldest first
   stim_row_type directed_rows[$];
   hist_rsp_type head;
   int           mismatches  = 0;
   int           cycle_count = 0;
   bit           idling_on   = 1'b1;
   logic [FLAGS_W-1:0] held_flags  = '0;   // what the random keyboard currently holds
   logic [KEY_W-1:0]   last_wr_key = '0;
   logic [COMBO_W-1:0] last_wr_combo = '0;

   key_modifier_histogram uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_key_code       (req_key_code),
      .req_shift_held     (req_shift_held),
      .req_control_held   (req_control_held),
      .req_option_held    (req_option_held),
      .req_command_held   (req_command_held),
      .req_caps_lock_on   (req_caps_lock_on),
      .req_modifier_combo (req_modifier_combo),
      .req_write_value    (req_write_value),
      .rsp_valid          (rsp_valid),
      .rsp_counted        (rsp_counted),
      .rsp_count_value    (rsp_count_value),
      .rsp_combo_used     (rsp_combo_used),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // Watchdog: give up well past the slowest legal run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Flag watched by a modifier key; zero for ordinary keys
   function automatic logic [FLAGS_W-1:0] watched_flag(input logic [KEY_W-1:0] key);
      case (key)
         KEY_RIGHT_COMMAND, KEY_LEFT_COMMAND: return HOLD_COMMAND;
         KEY_LEFT_SHIFT, KEY_RIGHT_SHIFT:     return HOLD_SHIFT;
         KEY_LEFT_OPTION, KEY_RIGHT_OPTION:   return HOLD_OPTION;
         KEY_LEFT_CONTROL, KEY_RIGHT_CONTROL: return HOLD_CONTROL;
         KEY_CAPS_LOCK:                       return HOLD_CAPS;
         default:                             return HOLD_NONE;
      endcase
   endfunction

   // Apply one accepted word to the local tally and return the response it must cause
   function automatic hist_rsp_type histogram_step(input hist_req_type w);
      hist_rsp_type       r;
      logic [FLAGS_W-1:0] f;
      logic [11:0]        slot;
      logic               pressed;
      r.counted = 1'b0;
      r.value   = '0;
      r.used    = '0;
      f         = w.flags;
      // Direct table access: no effect on the last flags
      if (w.action == ACT_READ || w.action == ACT_WRITE) begin
         slot = {w.key, w.combo};
         if (w.action == ACT_WRITE)
            tally[slot] = w.wval;
         r.value = tally[slot];
         r.used  = w.combo;
         return r;
      end
      // Key-down always counts; flags-changed only on a rising edge of the key's own modifier
      if (w.action == ACT_KEY_DOWN)
         pressed = 1'b1;
      else
         pressed = (watched_flag(w.key) & f) != '0 && (watched_flag(w.key) & last_flags) == '0;
      last_flags = f;
      if (!pressed)
         return r;
      // Caps lock forces shift for keys whose mask bit is set
      if (f[FL_CAPS] && caps_mask[w.key[7:6]][w.key[5:0]])
         f[FL_SHIFT] = 1'b1;
      slot = {w.key, f[COMBO_W-1:0]};
      if (tally[slot] != COUNT_TOP)
         tally[slot] = tally[slot] + OUT_COUNT_W'(1);
      r.counted = 1'b1;
      r.value   = tally[slot];
      r.used    = f[COMBO_W-1:0];
      return r;
   endfunction

   task automatic add_row(input act_type action, input logic [KEY_W-1:0] key,
                          input logic [FLAGS_W-1:0] flags, input logic [COMBO_W-1:0] combo,
                          input logic [WVAL_W-1:0] wval, input bit typed,
                          input logic counted, input logic [OUT_COUNT_W-1:0] value,
                          input logic [COMBO_W-1:0] used);
      stim_row_type row;
      row.req   = '{action, key, flags, combo, wval};
      row.typed = typed;
      row.rsp   = '{counted, value, used};
      directed_rows.push_back(row);
   endtask

   // Offer one word, hold it until the block takes it, then log what it owes
   task automatic send_word(input stim_row_type row);
      hist_rsp_type predicted;
      // Drop start for a short gap now and then, so gaps land on every phase of the work
      if (idling_on && $urandom_range(99) < 50) begin
         start <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      start              <= 1'b1;
      req_action         <= row.req.action;
      req_key_code       <= row.req.key;
      req_shift_held     <= row.req.flags[FL_SHIFT];
      req_control_held   <= row.req.flags[FL_CONTROL];
      req_option_held    <= row.req.flags[FL_OPTION];
      req_command_held   <= row.req.flags[FL_COMMAND];
      req_caps_lock_on   <= row.req.flags[FL_CAPS];
      req_modifier_combo <= row.req.combo;
      req_write_value    <= row.req.wval;
      // busy read straight after the edge is its value at the edge
      do @(posedge clock); while (busy);
      predicted = histogram_step(row.req);
      awaited_tallies.push_back(row.typed ? row.rsp : predicted);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      caps_mask[idx] = data;
   endtask

   // Drain the block completely, then rewrite all four caps masks
   task automatic load_caps_masks(input logic [CSR_DATA_W-1:0] low,
                                  input logic [CSR_DATA_W-1:0] mid_low,
                                  input logic [CSR_DATA_W-1:0] mid_high,
                                  input logic [CSR_DATA_W-1:0] high);
      start <= 1'b0;
      @(posedge clock);
      while (awaited_tallies.size() != 0 || busy) @(posedge clock);
      csr_write(CSR_CAPS_LOW, low);
      csr_write(CSR_CAPS_MID_LOW, mid_low);
      csr_write(CSR_CAPS_MID_HIGH, mid_high);
      csr_write(CSR_CAPS_HIGH, high);
      csr_valid <= 1'b0;
   endtask

   // Random word: mostly plausible keyboard traffic, some noise
   function automatic stim_row_type random_word();
      stim_row_type row;
      int           pick;
      pick          = $urandom_range(99);
      row.typed     = 1'b0;
      row.rsp       = '{1'b0, '0, '0};
      row.req.flags = held_flags;
      row.req.combo = COMBO_W'($urandom_range(15));
      row.req.wval  = $urandom;
      // Half the words hit a narrow band round the modifier keys, so entries collide
      if ($urandom_range(1) != 0)
         row.req.key = 8'($urandom_range(KEY_RIGHT_CONTROL + 4, KEY_RIGHT_COMMAND - 4));
      else
         row.req.key = 8'($urandom);
      if (pick < 35) begin
         row.req.action = ACT_KEY_DOWN;
         if ($urandom_range(7) == 0) begin
            // hit the entry written last, often one near saturation
            row.req.key   = last_wr_key;
            row.req.flags = {1'b0, last_wr_combo};
         end else if ($urandom_range(4) == 0) begin
            row.req.flags = 5'($urandom);
         end
      end else if (pick < 70) begin
         row.req.action = ACT_FLAGS;
         if ($urandom_range(4) != 0) begin
            // a modifier key toggles its own flag
            row.req.key = 8'($urandom_range(KEY_RIGHT_CONTROL, KEY_RIGHT_COMMAND));
            held_flags ^= watched_flag(row.req.key);
         end else begin
            held_flags = 5'($urandom);
         end
         row.req.flags = held_flags;
      end else if (pick < 85) begin
         row.req.action = ACT_READ;
      end else begin
         row.req.action = ACT_WRITE;
         if ($urandom_range(3) == 0)
            row.req.wval = COUNT_TOP - $urandom_range(2);
         last_wr_key   = row.req.key;
         last_wr_combo = row.req.combo;
      end
      return row;
   endfunction

   // Response checker: the receiver cannot stall, so take every strobed word as it comes
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (awaited_tallies.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response word: counted %b value %h combo %h",
                        rsp_counted, rsp_count_value, rsp_combo_used);
         end else begin
            head = awaited_tallies.pop_front();
            if (rsp_counted !== head.counted || rsp_count_value !== head.value ||
                rsp_combo_used !== head.used) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch cycle %0d exp/got: counted %b/%b value %h/%h combo %h/%h",
                           cycle_count, head.counted, rsp_counted, head.value, rsp_count_value,
                           head.used, rsp_combo_used);
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      for (int i = 0; i < KEY_CODES*COMBOS; i++)
         tally[i] = '0;
      for (int i = 0; i < CAPS_REGS; i++)
         caps_mask[i] = '0;

      // Directed words. Columns: action, key, flags, combo, write value, typed?, expected
      // counted / value / combo. Mask setting for this part: low and high all ones,
      // mid-low clear, mid-high alternating (odd key codes set).
      // after reset: table is clear at both corners
      add_row(ACT_READ, 8'd0, HOLD_NONE, 4'd0, '0, 1'b1, 1'b0, 32'd0, 4'd0);
      add_row(ACT_READ, 8'd255, HOLD_NONE, 4'd15, '0, 1'b1, 1'b0, 32'd0, 4'd15);
      // key-down with no modifiers, then with everything held on the top key
      add_row(ACT_KEY_DOWN, 8'd0, HOLD_NONE, 4'd0, '0, 1'b1, 1'b1, 32'd1, 4'd0);
      add_row(ACT_KEY_DOWN, 8'd255,
              HOLD_SHIFT | HOLD_CONTROL | HOLD_OPTION | HOLD_COMMAND | HOLD_CAPS,
              4'd0, '1, 1'b1, 1'b1, 32'd1, 4'd15);
      // caps lock forces shift only where the key's mask bit is set
      add_row(ACT_KEY_DOWN, 8'd0, HOLD_CAPS, 4'd0, '0, 1'b1, 1'b1, 32'd1, 4'd1);
      add_row(ACT_KEY_DOWN, 8'd64, HOLD_CAPS, 4'd0, '0, 1'b0, 1'b0, 32'd0, 4'd0);
      add_row(ACT_KEY_DOWN, 8'd129, HOLD_CAPS | HOLD_COMMAND, 4'd0, '0, 1'b0,
              1'b0, 32'd0, 4'd0);
      // saturation: preload the top value, press, and read back
      add_row(ACT_WRITE, 8'd10, HOLD_NONE, 4'd3, 32'hFFFF_FFFF, 1'b1,
              1'b0, 32'hFFFF_FFFF, 4'd3);
      add_row(ACT_KEY_DOWN, 8'd10, HOLD_SHIFT | HOLD_CONTROL, 4'd0, '0, 1'b1,
              1'b1, 32'hFFFF_FFFF, 4'd3);
      add_row(ACT_WRITE, 8'd200, HOLD_NONE, 4'd0, 32'd0, 1'b1, 1'b0, 32'd0, 4'd0);
      add_row(ACT_WRITE, 8'd7, HOLD_NONE, 4'd5, 32'hFFFF_FFFE, 1'b1,
              1'b0, 32'hFFFF_FFFE, 4'd5);
      add_row(ACT_KEY_DOWN, 8'd7, HOLD_SHIFT | HOLD_OPTION, 4'd0, '0, 1'b1,
              1'b1, 32'hFFFF_FFFF, 4'd5);
      add_row(ACT_READ, 8'd7, HOLD_NONE, 4'd5, '0, 1'b1, 1'b0, 32'hFFFF_FFFF, 4'd5);
      // flags-changed: each modifier key, rising edge counts, held or falling does not
      add_row(ACT_FLAGS, KEY_RIGHT_COMMAND, HOLD_COMMAND, 4'd0, '0, 1'b1, 1'b1, 32'd1, 4'd8);
      add_row(ACT_FLAGS, KEY_LEFT_COMMAND, HOLD_COMMAND, 4'd0, '0, 1'b1, 1'b0, 32'd0, 4'd0);
      add_row(ACT_FLAGS, KEY_LEFT_SHIFT, HOLD_NONE, 4'd0, '0, 1'b1, 1'b0, 32'd0, 4'd0);
      add_row(ACT_FLAGS, KEY_RIGHT_SHIFT, HOLD_SHIFT, 4'd0, '0, 1'b1, 1'b1, 32'd1, 4'd1);
      add_row(ACT_FLAGS, KEY_LEFT_OPTION, HOLD_OPTION, 4'd0, '0, 1'b1, 1'b1, 32'd1, 4'd4);
      add_row(ACT_FLAGS, KEY_RIGHT_OPTION, HOLD_OPTION | HOLD_SHIFT, 4'd0, '0, 1'b1,
              1'b0, 32'd0, 4'd0);
      add_row(ACT_FLAGS, KEY_LEFT_CONTROL, HOLD_CONTROL, 4'd0, '0, 1'b1, 1'b1, 32'd1, 4'd2);
      add_row(ACT_FLAGS, KEY_RIGHT_CONTROL, HOLD_CONTROL | HOLD_COMMAND, 4'd0, '0, 1'b1,
              1'b0, 32'd0, 4'd0);
      // caps lock key itself: its edge counts, with shift forced by the mask
      add_row(ACT_FLAGS, KEY_CAPS_LOCK, HOLD_CAPS, 4'd0, '0, 1'b1, 1'b1, 32'd1, 4'd1);
      add_row(ACT_FLAGS, KEY_CAPS_LOCK, HOLD_CAPS, 4'd0, '0, 1'b1, 1'b0, 32'd0, 4'd0);
      // flags-changed on ordinary keys never counts
      add_row(ACT_FLAGS, 8'd53, HOLD_SHIFT, 4'd0, '0, 1'b1, 1'b0, 32'd0, 4'd0);
      add_row(ACT_FLAGS, 8'd63, HOLD_CONTROL, 4'd0, '0, 1'b1, 1'b0, 32'd0, 4'd0);

      // Hold reset, then let the clearing pass finish
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);

      load_caps_masks('1, '0, {32{2'b10}}, '1);
      foreach (directed_rows[i])
         send_word(directed_rows[i]);

      // Random phases, each under its own mask setting; the second one runs with no gaps
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       load_caps_masks('1, '1, '1, '1);
            1:       load_caps_masks('0, '0, '0, '0);
            default: load_caps_masks({$urandom, $urandom}, {$urandom, $urandom},
                                     {$urandom, $urandom}, {$urandom, $urandom});
         endcase
         idling_on = (p != 1);
         repeat (PHASE_WORDS) begin
            row = random_word();
            send_word(row);
         end
      end

      // Drain, then keep watching for any stray word before the verdict
      start <= 1'b0;
      @(posedge clock);
      while (awaited_tallies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && awaited_tallies.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/kmh_pkg.sv
sv/kmh_ram.sv
sv/kmh_decode.sv
sv/key_modifier_histogram.sv
test/key_modifier_histogram_tb.sv
